// File: sv/fwnp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fwnp_pkg
// Shared sizes, request kinds and response status codes for the linear
// queue with negative purge.
// ----------------------------------------------------------------------------
package fwnp_pkg;

	localparam int DEPTH  = 128;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int WORD_W = 32;
	localparam int OCC_W  = 8;

	typedef enum logic [1:0] {
		K_PUSH  = 2'd0,
		K_POP   = 2'd1,
		K_PURGE = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

endpackage

`default_nettype wire

// File: sv/fifo_with_negative_purge.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fifo_with_negative_purge
// Linear (non-circular) queue of signed words in a single-port-write,
// single-port-read synchronous RAM, with push, pop and purge-negatives.
//
//   channel | handshake             | payload
//   --------+-----------------------+------------------------------
//   req     | req_valid / req_stall | kind, value
//   rsp     | rsp_valid / rsp_stall | status, data, occupancy
//
// Push, refused push, refused pop and empty purge: answered from S_IDLE.
// Pop: goes through S_POP behind the registered RAM read.
// Purge: walks the held entries in S_WALK; one RAM read and at most one write each.
// One request in flight; req_stall is high until its response is registered
// and while a registered response is stalled.
// Reset is asynchronous; the RAM contents are not cleared.
// ----------------------------------------------------------------------------
module fifo_with_negative_purge
	import fwnp_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     req_valid,
	output logic                          req_stall,
	input  wire logic [1:0]               kind,
	input  wire logic signed [WORD_W-1:0] value,
	output logic                          rsp_valid,
	input  wire logic                     rsp_stall,
	output logic [1:0]                    status,
	output logic signed [WORD_W-1:0]      data,
	output logic [OCC_W-1:0]              occupancy
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_POP  = 3'b010,
		S_WALK = 3'b100
	} state_t;

	function automatic logic [OCC_W-1:0] occ_of(input logic e,
		input logic [IDX_W-1:0] h, input logic [IDX_W-1:0] t);
		logic [CNT_W-1:0] cnt;
		cnt = CNT_W'(t) - CNT_W'(h) + CNT_W'(1);
		return e ? '0 : OCC_W'(cnt);
	endfunction

	logic [WORD_W-1:0] slots [DEPTH];

	state_t            state_q, state_d;
	logic [IDX_W-1:0]  head_q, head_d;
	logic [IDX_W-1:0]  tail_q, tail_d;
	logic              empty_q, empty_d;
	logic [IDX_W-1:0]  rd_idx_q, rd_idx_d;
	logic [CNT_W-1:0]  dst_q, dst_d;
	logic              last_q, last_d;
	logic [WORD_W-1:0] rd_data_q;

	logic              rsp_valid_q;
	status_t           status_q;
	logic [WORD_W-1:0] data_q;
	logic [OCC_W-1:0]  occ_q;

	logic              req_fire;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	logic [WORD_W-1:0] wr_data;
	logic [IDX_W-1:0]  rd_addr;
	logic              load;
	status_t           st_d;
	logic [WORD_W-1:0] dat_d;
	logic [OCC_W-1:0]  occ_d;
	logic              keep;
	logic [CNT_W-1:0]  dst_n;

	assign req_stall = (state_q != S_IDLE) || (rsp_valid_q && rsp_stall);
	assign req_fire  = req_valid && !req_stall;
	assign keep      = !rd_data_q[WORD_W-1];
	assign dst_n     = dst_q + CNT_W'(keep);

	always_comb begin
		state_d  = state_q;
		head_d   = head_q;
		tail_d   = tail_q;
		empty_d  = empty_q;
		rd_idx_d = rd_idx_q;
		dst_d    = dst_q;
		last_d   = last_q;
		wr_en    = 1'b0;
		wr_addr  = dst_q[IDX_W-1:0];
		wr_data  = rd_data_q;
		rd_addr  = (state_q == S_WALK) ? rd_idx_q : head_q;
		load     = 1'b0;
		st_d     = ST_DONE;
		dat_d    = '0;
		occ_d    = occ_of(empty_q, head_q, tail_q);
		unique case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					unique case (kind)
						K_PUSH: begin
							load = 1'b1;
							if (empty_q) begin
								head_d  = '0;
								tail_d  = '0;
								empty_d = 1'b0;
								wr_en   = 1'b1;
								wr_addr = '0;
								wr_data = value;
								occ_d   = OCC_W'(1);
							end else if (tail_q == IDX_W'(DEPTH - 1)) begin
								st_d = ST_FULL;
							end else begin
								tail_d  = tail_q + IDX_W'(1);
								wr_en   = 1'b1;
								wr_addr = tail_q + IDX_W'(1);
								wr_data = value;
								occ_d   = occ_of(1'b0, head_q, tail_q + IDX_W'(1));
							end
						end
						K_POP: begin
							if (empty_q) begin
								load = 1'b1;
								st_d = ST_EMPTY;
							end else begin
								state_d = S_POP;
							end
						end
						K_PURGE: begin
							if (empty_q) begin
								load = 1'b1;
							end else begin
								// head is being read now; walk continues from head + 1
								state_d  = S_WALK;
								rd_idx_d = head_q + IDX_W'(1);
								dst_d    = CNT_W'(head_q);
								last_d   = (head_q == tail_q);
							end
						end
						default: begin
							load = 1'b1;
						end
					endcase
				end
			end
			S_POP: begin
				load    = 1'b1;
				dat_d   = rd_data_q;
				state_d = S_IDLE;
				if (head_q == tail_q) begin
					head_d  = '0;
					tail_d  = '0;
					empty_d = 1'b1;
					occ_d   = '0;
				end else begin
					head_d = head_q + IDX_W'(1);
					occ_d  = occ_of(1'b0, head_q + IDX_W'(1), tail_q);
				end
			end
			S_WALK: begin
				// rd_data_q holds the entry issued last cycle; writes trail reads
				wr_en = keep;
				dst_d = dst_n;
				if (last_q) begin
					load    = 1'b1;
					state_d = S_IDLE;
					if (dst_n == CNT_W'(head_q)) begin
						head_d  = '0;
						tail_d  = '0;
						empty_d = 1'b1;
						occ_d   = '0;
					end else begin
						tail_d = IDX_W'(dst_n - CNT_W'(1));
						occ_d  = OCC_W'(dst_n - CNT_W'(head_q));
					end
				end else begin
					rd_idx_d = rd_idx_q + IDX_W'(1);
					last_d   = (rd_idx_q == tail_q);
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			empty_q     <= 1'b1;
			rd_idx_q    <= '0;
			dst_q       <= '0;
			last_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			head_q   <= head_d;
			tail_q   <= tail_d;
			empty_q  <= empty_d;
			rd_idx_q <= rd_idx_d;
			dst_q    <= dst_d;
			last_q   <= last_d;
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			status_q <= st_d;
			data_q   <= dat_d;
			occ_q    <= occ_d;
		end
	end

	// queue storage: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			slots[wr_addr] <= wr_data;
		end
		rd_data_q <= slots[rd_addr];
	end

	assign rsp_valid = rsp_valid_q;
	assign status    = status_q;
	assign data      = data_q;
	assign occupancy = occ_q;

endmodule

`default_nettype wire

// File: sv/fwnp_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fwnp_chk
// Port-level checks for the linear queue, bound to the top level.
// ----------------------------------------------------------------------------
module fwnp_chk
	import fwnp_pkg::*;
(
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     req_stall,
	input wire logic                     rsp_valid,
	input wire logic                     rsp_stall,
	input wire logic [1:0]               status,
	input wire logic signed [WORD_W-1:0] data,
	input wire logic [OCC_W-1:0]         occupancy
);

	// stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(data)
			&& $stable(occupancy))
		else $error("response changed while stalled");

	// no new request while a response is backed up
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |-> req_stall)
		else $error("request accepted over a stalled response");

	a_empty_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_EMPTY |-> data == '0 && occupancy == '0)
		else $error("refused pop reports data or entries");

	a_full_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_FULL |-> data == '0 && occupancy != '0)
		else $error("refused push with data or empty queue");

	// non-zero data only comes out of a successful pop, which leaves room
	a_pop_occ: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && data != '0 |-> status == ST_DONE
			&& occupancy != OCC_W'(DEPTH))
		else $error("data on a response that is not a pop");

endmodule

bind fifo_with_negative_purge fwnp_chk u_fwnp_chk (.*);

`default_nettype wire

// File: tb/fifo_with_negative_purge_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_with_negative_purge_tb
// Self-checking bench for the linear queue with negative purge. A shadow
// queue predicts status, popped word and occupancy for every accepted
// request. Directed corner requests run first, then random phases: fills to
// full, drains, purges with mixed and all-negative contents, and mixed
// traffic. The sender idles in random bursts; the receiver stalls on its
// own pattern.
// ----------------------------------------------------------------------------
module fifo_with_negative_purge_tb;
	import fwnp_pkg::*;

	localparam logic [1:0] K_SPARE = 2'd3;   // unused code, must be ignored

	typedef struct packed {
		logic [1:0]               op;
		logic signed [WORD_W-1:0] word;
	} req_t;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [WORD_W-1:0] data;
		logic [OCC_W-1:0]         occupancy;
	} rsp_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     req_valid = 1'b0;
	logic                     req_stall;
	logic [1:0]               kind = K_PUSH;
	logic signed [WORD_W-1:0] value = '0;
	logic                     rsp_valid;
	logic                     rsp_stall = 1'b0;
	logic [1:0]               status;
	logic signed [WORD_W-1:0] data;
	logic [OCC_W-1:0]         occupancy;

	req_t req_backlog[$];
	rsp_t expected_rsp[$];
	int   n_planned = 0;
	int   n_taken = 0;
	int   n_errors = 0;
	bit   req_acc = 1'b0;

	// shadow queue state
	logic signed [WORD_W-1:0] q_slots [DEPTH];
	int unsigned              q_head = 0;
	int unsigned              q_tail = 0;
	bit                       q_empty = 1'b1;

	fifo_with_negative_purge u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.kind      (kind),
		.value     (value),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.status    (status),
		.data      (data),
		.occupancy (occupancy)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void clear_shadow();
		q_head = 0;
		q_tail = 0;
		q_empty = 1'b1;
	endfunction

	function automatic rsp_t predict_response(logic [1:0] op, logic signed [WORD_W-1:0] word);
		rsp_t        r;
		int unsigned keep;
		r.status = ST_DONE;
		r.data = '0;
		case (op)
			K_PUSH: begin
				if (q_empty) begin
					q_head = 0;
					q_tail = 0;
					q_empty = 1'b0;
					q_slots[0] = word;
				end else if (q_tail >= DEPTH - 1) begin
					r.status = ST_FULL;
				end else begin
					q_tail++;
					q_slots[q_tail] = word;
				end
			end
			K_POP: begin
				if (q_empty) begin
					r.status = ST_EMPTY;
				end else begin
					r.data = q_slots[q_head];
					if (q_head == q_tail)
						clear_shadow();
					else
						q_head++;
				end
			end
			K_PURGE: begin
				if (!q_empty) begin
					// survivors packed down from the head, order kept
					keep = q_head;
					for (int unsigned i = q_head; i <= q_tail; i++) begin
						if (!q_slots[i][WORD_W-1]) begin
							q_slots[keep] = q_slots[i];
							keep++;
						end
					end
					if (keep == q_head)
						clear_shadow();
					else
						q_tail = keep - 1;
				end
			end
			default: ;
		endcase
		r.occupancy = q_empty ? '0 : OCC_W'(q_tail - q_head + 1);
		return r;
	endfunction

	task automatic plan(logic [1:0] op, logic signed [WORD_W-1:0] word);
		req_t r;
		r.op = op;
		r.word = word;
		req_backlog.push_back(r);
		n_planned++;
	endtask

	function automatic logic signed [WORD_W-1:0] pick_word();
		case ($urandom_range(0, 9))
			0:       return 32'sh7FFF_FFFF;
			1:       return 32'sh8000_0000;
			2:       return '0;
			3:       return -32'sd1;
			4:       return $urandom_range(1, 100);
			5:       return -$signed({1'b0, 31'($urandom_range(1, 100))});
			default: return $urandom;
		endcase
	endfunction

	function automatic logic signed [WORD_W-1:0] pick_negative();
		return {1'b1, 31'($urandom)};
	endfunction

	// requests accepted and responses checked at the rising edge
	always @(posedge clk) begin : observe
		rsp_t want;
		req_acc = 1'b0;
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				req_acc = 1'b1;
				expected_rsp.push_back(predict_response(kind, value));
				n_taken++;
			end
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsp.size() == 0) begin
					$error("response with no request outstanding");
					n_errors++;
				end else begin
					want = expected_rsp.pop_front();
					if (status !== want.status) begin
						$error("status mismatch: expected %0d, got %0d", want.status, status);
						n_errors++;
					end
					if (data !== want.data) begin
						$error("data mismatch: expected %0d, got %0d", want.data, data);
						n_errors++;
					end
					if (occupancy !== want.occupancy) begin
						$error("occupancy mismatch: expected %0d, got %0d",
							want.occupancy, occupancy);
						n_errors++;
					end
				end
			end
		end
	end

	// request driver: bursts with random gaps in between
	int burst_left = 0;
	int gap_left = 0;

	always @(negedge clk) begin : drive
		req_t nxt;
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (!req_valid || req_acc) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				req_valid <= 1'b0;
			end else if (req_backlog.size() != 0) begin
				nxt = req_backlog.pop_front();
				req_valid <= 1'b1;
				kind <= nxt.op;
				value <= nxt.word;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// response stall: mode and mask drawn at random, re-rolled as stall_tick advances
	int          stall_tick = 0;
	int          stall_mode = 0;
	logic [15:0] stall_mask = '0;

	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (stall_tick % 64 == 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_mask = $urandom;
			end
			case (stall_mode)
				0:       rsp_stall <= 1'b0;
				1:       rsp_stall <= stall_mask[stall_tick % 16];
				2:       rsp_stall <= ($urandom_range(0, 3) != 0);
				default: rsp_stall <= ($urandom_range(0, 5) == 0);
			endcase
			stall_tick++;
		end
	end

	initial begin
		int seg;
		int first_fill;
		for (int i = 0; i < DEPTH; i++)
			q_slots[i] = '0;

		// directed corners
		plan(K_POP, '0);                   // pop when empty
		plan(K_PURGE, '0);                 // purge when empty
		plan(K_SPARE, 32'sh5A5A_5A5A);     // unused code when empty
		plan(K_PUSH, 32'sh7FFF_FFFF);      // push into empty queue
		plan(K_PUSH, 32'sh8000_0000);
		plan(K_PUSH, '0);
		plan(K_PUSH, -32'sd1);
		plan(K_PUSH, 32'sd5);
		plan(K_SPARE, -32'sd1);
		plan(K_PURGE, 32'sh1234_5678);     // drops the two negatives
		plan(K_POP, 32'sh1234_5678);       // value ignored on pop
		plan(K_POP, '0);
		plan(K_POP, '0);                   // last entry, indices back to zero
		plan(K_POP, '0);
		plan(K_PUSH, -32'sd7);
		plan(K_PUSH, 32'sh8000_0000);
		plan(K_PURGE, '0);                 // nothing survives
		plan(K_PUSH, 32'sd1);
		plan(K_PUSH, -32'sd9);
		plan(K_PUSH, 32'sd2);
		plan(K_PURGE, '0);
		plan(K_POP, '0);

		// random phases; the first one fills the queue
		first_fill = 1;
		while (n_planned < 530) begin
			seg = first_fill ? 0 : $urandom_range(0, 29);
			first_fill = 0;
			if (seg == 0) begin
				// fill to full, then pop a few: tail stays on the last slot
				repeat (130) plan(K_PUSH, pick_word());
				repeat ($urandom_range(1, 4)) plan(K_POP, $urandom);
				repeat (2) plan(K_PUSH, pick_word());
				if ($urandom_range(0, 1)) plan(K_PURGE, $urandom);
			end else if (seg <= 5) begin
				repeat ($urandom_range(1, 40)) plan(K_POP, $urandom);
			end else if (seg <= 10) begin
				repeat ($urandom_range(1, 12)) plan(K_PUSH, pick_word());
				plan(K_PURGE, $urandom);
			end else if (seg <= 13) begin
				repeat ($urandom_range(1, 6)) plan(K_PUSH, pick_negative());
				plan(K_PURGE, $urandom);
			end else begin
				repeat ($urandom_range(1, 20)) begin
					case ($urandom_range(0, 9))
						0, 1, 2, 3, 4: plan(K_PUSH, pick_word());
						5, 6, 7:       plan(K_POP, $urandom);
						8:             plan(K_PURGE, $urandom);
						default:       plan(K_SPARE, $urandom);
					endcase
				end
			end
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (n_taken < n_planned) @(posedge clk);
		while (expected_rsp.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (n_errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
